>>> hdl/lob_pkg.sv
package lob_pkg;

    localparam int ID_W    = 32;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        CMD_LIMIT  = 2'd0,
        CMD_MARKET = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_TRADE     = 3'd0,
        KIND_RESTED    = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_CANCELLED = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_REJECTED  = 3'd5,
        KIND_FULL      = 3'd6,
        KIND_CLEARED   = 3'd7
    } t_kind;

    typedef struct packed {
        logic  in_ready;
        logic  clear_book;
        logic  take_id;
        logic  scan_start;
        logic  fill;
        logic  free_start;
        logic  free_step;
        logic  cancel_kill;
        logic  emit_final;
        t_kind fin_kind;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        t_cmd cmd;
        logic qty_zero;
        logic scan_last;
        logic best_found;
        logic fills_max;
        logic free_here;
        logic free_last;
        logic out_free;
    } t_stat;

endpackage

>>> hdl/lob_in_if.sv
interface lob_in_if #(
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic                  side;
    logic [PRICE_BITS-1:0] limit_price;
    logic [QTY_BITS-1:0]   quantity;
    logic [31:0]           target_id;

    modport source (output valid, cmd, side, limit_price, quantity, target_id, input ready);
    modport sink   (input valid, cmd, side, limit_price, quantity, target_id, output ready);
endinterface

>>> hdl/lob_out_if.sv
interface lob_out_if #(
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            kind;
    logic [31:0]           subject_id;
    logic [31:0]           bid_oid;
    logic [31:0]           ask_oid;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   trade_quantity;
    logic [QTY_BITS-1:0]   remaining_quantity;
    logic [10:0]           resting_count;
    logic                  last;

    modport source (output valid, kind, subject_id, bid_oid, ask_oid, trade_price,
                    trade_quantity, remaining_quantity, resting_count, last, input ready);
    modport sink   (input valid, kind, subject_id, bid_oid, ask_oid, trade_price,
                    trade_quantity, remaining_quantity, resting_count, last, output ready);
endinterface

>>> hdl/lob_ctrl.sv
module lob_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lob_pkg::t_stat i_stat,
    output lob_pkg::t_ctrl o_ctrl
);
    import lob_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_MSCAN    = 9'b000000100,
        S_MDECIDE  = 9'b000001000,
        S_FILL     = 9'b000010000,
        S_FSCAN    = 9'b000100000,
        S_CSCAN    = 9'b001000000,
        S_CDECIDE  = 9'b010000000,
        S_FIN      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_DONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_ctrl  = '0;
        o_ctrl.fin_kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_stat.in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.cmd)
                    CMD_CLEAR: begin
                        o_ctrl.clear_book = 1'b1;
                        n_kind  = KIND_CLEARED;
                        n_state = S_FIN;
                    end
                    CMD_CANCEL: begin
                        o_ctrl.scan_start = 1'b1;
                        n_state = S_CSCAN;
                    end
                    default: begin
                        if (i_stat.qty_zero) begin
                            n_kind  = KIND_REJECTED;
                            n_state = S_FIN;
                        end else begin
                            o_ctrl.take_id    = 1'b1;
                            o_ctrl.scan_start = 1'b1;
                            n_state = S_MSCAN;
                        end
                    end
                endcase
            end
            S_MSCAN: begin
                if (i_stat.scan_last) n_state = S_MDECIDE;
            end
            S_MDECIDE: begin
                if (!i_stat.qty_zero && !i_stat.fills_max && i_stat.best_found) begin
                    n_state = S_FILL;
                end else if (i_stat.qty_zero || i_stat.cmd == CMD_MARKET) begin
                    n_kind  = KIND_DONE;
                    n_state = S_FIN;
                end else begin
                    o_ctrl.free_start = 1'b1;
                    n_state = S_FSCAN;
                end
            end
            S_FILL: begin
                if (i_stat.out_free) begin
                    o_ctrl.fill       = 1'b1;
                    o_ctrl.scan_start = 1'b1;
                    n_state = S_MSCAN;
                end
            end
            S_FSCAN: begin
                o_ctrl.free_step = 1'b1;
                if (i_stat.free_here) begin
                    n_kind  = KIND_RESTED;
                    n_state = S_FIN;
                end else if (i_stat.free_last) begin
                    n_kind  = KIND_FULL;
                    n_state = S_FIN;
                end
            end
            S_CSCAN: begin
                if (i_stat.scan_last) n_state = S_CDECIDE;
            end
            S_CDECIDE: begin
                o_ctrl.cancel_kill = i_stat.best_found;
                n_kind  = i_stat.best_found ? KIND_CANCELLED : KIND_NOT_FOUND;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_ctrl.emit_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> hdl/lob_dp.sv
module lob_dp #(
    parameter int ORDER_SLOTS = 32,
    parameter int PRICE_BITS  = 16,
    parameter int QTY_BITS    = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lob_pkg::t_ctrl i_ctrl,
    output lob_pkg::t_stat o_stat,
    lob_in_if.sink         i_ord,
    lob_out_if.source      o_res
);
    import lob_pkg::*;

    localparam int AW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam logic [AW-1:0] LAST = AW'(ORDER_SLOTS - 1);
    localparam logic [CW-1:0] FULL_N = CW'(ORDER_SLOTS);

    typedef struct packed {
        logic                  is_bid;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        logic [ID_W-1:0]       id;
    } t_slot;

    t_slot                  r_mem [ORDER_SLOTS];
    t_slot                  r_rd;
    logic [ORDER_SLOTS-1:0] r_valid;
    logic [CW-1:0]          r_count;

    t_cmd                  r_cmd;
    logic                  r_side;
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_BITS-1:0]   r_qty;
    logic [ID_W-1:0]       r_target;
    logic [ID_W-1:0]       r_id;
    logic [ID_W-1:0]       r_next_id;
    logic [CW-1:0]         r_nfill;

    logic [AW-1:0] r_addr;
    logic          r_issuing;
    logic          r_eval_valid;
    logic [AW-1:0] r_eval_idx;

    logic                  r_best_found;
    logic [AW-1:0]         r_best_idx;
    logic [PRICE_BITS-1:0] r_best_price;
    logic [QTY_BITS-1:0]   r_best_qty;
    logic [ID_W-1:0]       r_best_id;

    logic                  r_out_valid;
    t_kind                 r_out_kind;
    logic [ID_W-1:0]       r_out_oid;
    logic [ID_W-1:0]       r_out_buyer;
    logic [ID_W-1:0]       r_out_seller;
    logic [PRICE_BITS-1:0] r_out_price;
    logic [QTY_BITS-1:0]   r_out_tqty;
    logic [QTY_BITS-1:0]   r_out_rem;
    logic [CW-1:0]         r_out_count;
    logic                  r_out_last;

    logic                  accept;
    logic                  out_free;
    logic                  cand_valid;
    logic                  match_ok;
    logic                  better;
    logic                  cancel_ok;
    logic                  hit;
    logic [QTY_BITS-1:0]   fill_qty;
    logic [QTY_BITS-1:0]   slot_left;
    logic                  free_here;
    logic                  rest_write;
    logic [ID_W-1:0]       id_inc;

    assign accept   = i_ord.valid && i_ctrl.in_ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign i_ord.ready = i_ctrl.in_ready;

    // candidate evaluation on the registered read
    assign cand_valid = r_valid[r_eval_idx];
    assign match_ok   = cand_valid && (r_rd.is_bid != r_side)
                     && (r_cmd == CMD_MARKET
                         || (r_side ? (r_rd.price <= r_price) : (r_rd.price >= r_price)));
    assign better     = !r_best_found
                     || ((r_rd.price == r_best_price) ? (r_rd.id < r_best_id)
                         : (r_side ? (r_rd.price < r_best_price) : (r_rd.price > r_best_price)));
    assign cancel_ok  = cand_valid && (r_rd.id == r_target) && !r_best_found;
    assign hit        = r_eval_valid && ((r_cmd == CMD_CANCEL) ? cancel_ok : (match_ok && better));

    assign fill_qty   = (r_qty < r_best_qty) ? r_qty : r_best_qty;
    assign slot_left  = r_best_qty - fill_qty;
    assign free_here  = !r_valid[r_addr];
    assign rest_write = i_ctrl.free_step && free_here;
    assign id_inc     = r_next_id + 1'b1;

    assign o_stat.in_valid   = i_ord.valid;
    assign o_stat.cmd        = r_cmd;
    assign o_stat.qty_zero   = (r_qty == '0);
    assign o_stat.scan_last  = r_eval_valid && (r_eval_idx == LAST);
    assign o_stat.best_found = r_best_found;
    assign o_stat.fills_max  = (r_nfill == FULL_N);
    assign o_stat.free_here  = free_here;
    assign o_stat.free_last  = (r_addr == LAST);
    assign o_stat.out_free   = out_free;

    // item registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= t_cmd'(i_ord.cmd);
            r_side   <= i_ord.side;
            r_price  <= i_ord.limit_price;
            r_qty    <= i_ord.quantity;
            r_target <= i_ord.target_id;
        end else if (i_ctrl.fill) begin
            r_qty <= r_qty - fill_qty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= ID_W'(1);
            r_nfill   <= '0;
        end else begin
            if (accept) r_nfill <= '0;
            else if (i_ctrl.fill) r_nfill <= r_nfill + 1'b1;
            if (i_ctrl.take_id) begin
                r_id      <= r_next_id;
                r_next_id <= (id_inc == '0) ? ID_W'(1) : id_inc;
            end
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill) begin
            r_mem[r_best_idx] <= '{is_bid: !r_side, price: r_best_price,
                                   qty: slot_left, id: r_best_id};
        end else if (rest_write) begin
            r_mem[r_addr] <= '{is_bid: r_side, price: r_price, qty: r_qty, id: r_id};
        end
        if (r_issuing) r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_ctrl.clear_book) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_ctrl.fill) begin
            if (slot_left == '0) begin
                r_valid[r_best_idx] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
        end else if (rest_write) begin
            r_valid[r_addr] <= 1'b1;
            r_count <= r_count + 1'b1;
        end else if (i_ctrl.cancel_kill) begin
            r_valid[r_best_idx] <= 1'b0;
            r_count <= r_count - 1'b1;
        end
    end

    // slot scan sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issuing    <= 1'b0;
            r_eval_valid <= 1'b0;
            r_eval_idx   <= '0;
        end else if (i_ctrl.scan_start) begin
            r_addr       <= '0;
            r_issuing    <= 1'b1;
            r_eval_valid <= 1'b0;
        end else if (i_ctrl.free_start) begin
            r_addr <= '0;
        end else if (i_ctrl.free_step) begin
            if (!free_here && r_addr != LAST) r_addr <= r_addr + 1'b1;
        end else begin
            r_eval_valid <= r_issuing;
            r_eval_idx   <= r_addr;
            if (r_issuing) begin
                if (r_addr == LAST) r_issuing <= 1'b0;
                else r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
        end else if (i_ctrl.scan_start) begin
            r_best_found <= 1'b0;
        end else if (hit) begin
            r_best_found <= 1'b1;
            r_best_idx   <= r_eval_idx;
            r_best_price <= r_rd.price;
            r_best_qty   <= r_rd.qty;
            r_best_id    <= r_rd.id;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.fill || i_ctrl.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill) begin
            r_out_kind   <= KIND_TRADE;
            r_out_oid    <= r_id;
            r_out_buyer  <= r_side ? r_id : r_best_id;
            r_out_seller <= r_side ? r_best_id : r_id;
            r_out_price  <= r_best_price;
            r_out_tqty   <= fill_qty;
            r_out_rem    <= r_qty - fill_qty;
            r_out_count  <= (slot_left == '0) ? (r_count - 1'b1) : r_count;
            r_out_last   <= 1'b0;
        end else if (i_ctrl.emit_final) begin
            r_out_kind   <= i_ctrl.fin_kind;
            r_out_buyer  <= '0;
            r_out_seller <= '0;
            r_out_price  <= '0;
            r_out_tqty   <= '0;
            r_out_count  <= r_count;
            r_out_last   <= 1'b1;
            case (i_ctrl.fin_kind) inside
                KIND_REJECTED, KIND_CLEARED:   r_out_oid <= '0;
                KIND_CANCELLED, KIND_NOT_FOUND: r_out_oid <= r_target;
                default:                        r_out_oid <= r_id;
            endcase
            case (i_ctrl.fin_kind) inside
                KIND_DONE, KIND_RESTED, KIND_FULL: r_out_rem <= r_qty;
                default:                           r_out_rem <= '0;
            endcase
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.kind               = r_out_kind;
    assign o_res.subject_id         = r_out_oid;
    assign o_res.bid_oid            = r_out_buyer;
    assign o_res.ask_oid            = r_out_seller;
    assign o_res.trade_price        = r_out_price;
    assign o_res.trade_quantity     = r_out_tqty;
    assign o_res.remaining_quantity = r_out_rem;
    assign o_res.resting_count      = COUNT_W'(r_out_count);
    assign o_res.last               = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_N)
        else $error("resting count beyond slot count");

    a_fill_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.fill |-> r_best_found && r_valid[r_best_idx] && r_qty != '0)
        else $error("fill without a valid best order");

    a_rest_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rest_write |=> r_valid[$past(r_addr)])
        else $error("rested order not marked valid");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.fill || i_ctrl.emit_final) |-> out_free)
        else $error("result loaded over a waiting result");

endmodule

>>> hdl/limit_order_book_matcher.sv
// channel  direction  carries
// i_ord    in         cmd, side, limit_price, quantity, target_id
// o_res    out        kind, order ids, trade price and quantity, remaining, count, last
//
// each slot scan reads one entry a cycle and ends in a decision
// a limit or market order takes one scan per fill plus one more,
// then a search for a free slot when it rests
// cancel takes one scan and its decision; clear and reject go straight to the final result
// synchronous active-low reset empties the book and sets the next id to one
// a stalled result holds the block before the next fill or final result
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = 32,
    parameter int PRICE_BITS  = 16,
    parameter int QTY_BITS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lob_in_if.sink    i_ord,
    lob_out_if.source o_res
);
    import lob_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    lob_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    lob_dp #(
        .ORDER_SLOTS (ORDER_SLOTS),
        .PRICE_BITS  (PRICE_BITS),
        .QTY_BITS    (QTY_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .i_ord   (i_ord),
        .o_res   (o_res)
    );

endmodule

>>> verif/tb_limit_order_book_matcher.sv
`timescale 1ns / 100ps

module tb_limit_order_book_matcher;
    import lob_pkg::*;

    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        t_cmd        cmd;
        logic        side;
        logic [15:0] limit_price;
        logic [15:0] quantity;
        logic [31:0] target_id;
    } t_order;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] subject_id;
        logic [31:0] bid_oid;
        logic [31:0] ask_oid;
        logic [15:0] trade_price;
        logic [15:0] trade_quantity;
        logic [15:0] remaining_quantity;
        logic [10:0] resting_count;
        logic        last;
    } t_fill_report;

    logic i_clk;
    logic i_rst_n;

    lob_in_if  #(.PRICE_BITS(16), .QTY_BITS(16)) ord_ch ();
    lob_out_if #(.PRICE_BITS(16), .QTY_BITS(16)) res_ch ();

    limit_order_book_matcher #(.ORDER_SLOTS(SLOTS), .PRICE_BITS(16), .QTY_BITS(16)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ord   (ord_ch.sink),
        .o_res   (res_ch.source)
    );

    // book mirror
    logic        bk_valid [SLOTS];
    logic        bk_bid   [SLOTS];
    logic [15:0] bk_price [SLOTS];
    logic [15:0] bk_qty   [SLOTS];
    logic [31:0] bk_id    [SLOTS];
    logic [31:0] bk_next_id;
    logic [10:0] bk_count;

    t_order       order_queue[$];
    t_fill_report report_queue[$];
    logic [31:0]  live_ids[$];

    int   errors = 0;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_fill_report mk(t_kind k, logic [31:0] oid, logic [31:0] b,
                                        logic [31:0] s, logic [15:0] p, logic [15:0] q,
                                        logic [15:0] r, logic l);
        t_fill_report x;
        x.kind = k; x.subject_id = oid; x.bid_oid = b; x.ask_oid = s;
        x.trade_price = p; x.trade_quantity = q; x.remaining_quantity = r;
        x.resting_count = bk_count; x.last = l;
        return x;
    endfunction

    function automatic void queue_report(t_fill_report x);
        report_queue.insert(report_queue.size(), x);
    endfunction

    function automatic void post_order(t_order o);
        order_queue.insert(order_queue.size(), o);
    endfunction

    task automatic match_order(input t_order o);
        logic [15:0] qty;
        logic [31:0] id;
        logic [15:0] fill;
        logic        mkt;
        int          nfill;
        int          best;
        logic        better;
        qty = o.quantity;
        nfill = 0;
        mkt = (o.cmd == CMD_MARKET);
        if (o.cmd == CMD_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) bk_valid[i] = 0;
            bk_count = 0;
            queue_report(mk(KIND_CLEARED, '0, '0, '0, '0, '0, '0, 1'b1));
            return;
        end
        if (o.cmd == CMD_CANCEL) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (bk_valid[i] && bk_id[i] == o.target_id) begin
                    bk_valid[i] = 0;
                    bk_count--;
                    queue_report(mk(KIND_CANCELLED, o.target_id, '0, '0, '0, '0, '0, 1'b1));
                    return;
                end
            end
            queue_report(mk(KIND_NOT_FOUND, o.target_id, '0, '0, '0, '0, '0, 1'b1));
            return;
        end
        if (qty == 0) begin
            queue_report(mk(KIND_REJECTED, '0, '0, '0, '0, '0, '0, 1'b1));
            return;
        end
        id = bk_next_id;
        bk_next_id = bk_next_id + 1;
        if (bk_next_id == 0) bk_next_id = 1;
        live_ids.insert(live_ids.size(), id);
        while (qty > 0 && nfill < SLOTS) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!bk_valid[i] || bk_bid[i] == o.side) continue;
                if (!mkt) begin
                    if (o.side && bk_price[i] > o.limit_price) continue;
                    if (!o.side && bk_price[i] < o.limit_price) continue;
                end
                if (best < 0) better = 1;
                else if (bk_price[i] == bk_price[best]) better = bk_id[i] < bk_id[best];
                else if (o.side) better = bk_price[i] < bk_price[best];
                else better = bk_price[i] > bk_price[best];
                if (better) best = i;
            end
            if (best < 0) break;
            fill = (qty < bk_qty[best]) ? qty : bk_qty[best];
            qty -= fill;
            bk_qty[best] -= fill;
            if (bk_qty[best] == 0) begin
                bk_valid[best] = 0;
                bk_count--;
            end
            queue_report(mk(KIND_TRADE, id, o.side ? id : bk_id[best],
                            o.side ? bk_id[best] : id, bk_price[best], fill, qty, 1'b0));
            nfill++;
        end
        if (qty == 0 || mkt) begin
            queue_report(mk(KIND_DONE, id, '0, '0, '0, '0, qty, 1'b1));
            return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!bk_valid[i]) begin
                bk_valid[i] = 1; bk_bid[i] = o.side; bk_price[i] = o.limit_price;
                bk_qty[i] = qty; bk_id[i] = id;
                bk_count++;
                queue_report(mk(KIND_RESTED, id, '0, '0, '0, '0, qty, 1'b1));
                return;
            end
        end
        queue_report(mk(KIND_FULL, id, '0, '0, '0, '0, qty, 1'b1));
    endtask

    function automatic t_order make_order(t_cmd c, logic s, logic [15:0] p, logic [15:0] q,
                                          logic [31:0] t);
        t_order o;
        o.cmd = c; o.side = s; o.limit_price = p; o.quantity = q; o.target_id = t;
        return o;
    endfunction

    function automatic t_order random_order();
        t_order o;
        int r;
        r = $urandom_range(0, 99);
        o.side = 1'($urandom_range(0, 1));
        o.limit_price = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(1000 + $urandom_range(0, 12));
        o.quantity = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
        o.target_id = $urandom;
        if (r < 60) o.cmd = CMD_LIMIT;
        else if (r < 75) o.cmd = CMD_MARKET;
        else if (r < 96) begin
            o.cmd = CMD_CANCEL;
            if ($urandom_range(0, 3) != 0 && live_ids.size() > 0)
                o.target_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        end else o.cmd = CMD_CLEAR;
        if ($urandom_range(0, 29) == 0) o.quantity = 0;
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ord_ch.valid       <= 0;
            ord_ch.cmd         <= CMD_LIMIT;
            ord_ch.side        <= 0;
            ord_ch.limit_price <= '0;
            ord_ch.quantity    <= '0;
            ord_ch.target_id   <= '0;
        end else if (!ord_ch.valid || ord_ch.ready) begin
            if (order_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_order o;
                o = order_queue[0];
                order_queue.delete(0);
                match_order(o);
                ord_ch.valid       <= 1;
                ord_ch.cmd         <= o.cmd;
                ord_ch.side        <= o.side;
                ord_ch.limit_price <= o.limit_price;
                ord_ch.quantity    <= o.quantity;
                ord_ch.target_id   <= o.target_id;
            end else begin
                ord_ch.valid <= 0;
            end
        end
    end

    // long receiver hold counter
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                t_fill_report got;
                t_fill_report want;
                got = {t_kind'(res_ch.kind), res_ch.subject_id, res_ch.bid_oid,
                       res_ch.ask_oid, res_ch.trade_price, res_ch.trade_quantity,
                       res_ch.remaining_quantity, res_ch.resting_count, res_ch.last};
                if (report_queue.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = report_queue[0];
                    report_queue.delete(0);
                    if (got.kind !== want.kind)
                        $display("%0t kind exp %0d got %0d", $time, want.kind, got.kind);
                    if (got.subject_id !== want.subject_id)
                        $display("%0t subject_id exp %0d got %0d", $time, want.subject_id,
                                 got.subject_id);
                    if (got.bid_oid !== want.bid_oid)
                        $display("%0t bid_oid exp %0d got %0d", $time, want.bid_oid, got.bid_oid);
                    if (got.ask_oid !== want.ask_oid)
                        $display("%0t ask_oid exp %0d got %0d", $time, want.ask_oid, got.ask_oid);
                    if (got.trade_price !== want.trade_price)
                        $display("%0t trade_price exp %0d got %0d", $time, want.trade_price,
                                 got.trade_price);
                    if (got.trade_quantity !== want.trade_quantity)
                        $display("%0t trade_quantity exp %0d got %0d", $time,
                                 want.trade_quantity, got.trade_quantity);
                    if (got.remaining_quantity !== want.remaining_quantity)
                        $display("%0t remaining exp %0d got %0d", $time,
                                 want.remaining_quantity, got.remaining_quantity);
                    if (got.resting_count !== want.resting_count)
                        $display("%0t resting_count exp %0d got %0d", $time,
                                 want.resting_count, got.resting_count);
                    if (got.last !== want.last)
                        $display("%0t last exp %0d got %0d", $time, want.last, got.last);
                    if (got !== want) errors++;
                end
            end
            if (hold_cycles > 0) begin
                res_ch.ready <= 0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic drain();
        while (order_queue.size() > 0 || ord_ch.valid || report_queue.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) post_order(random_order());
        drain();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            bk_valid[i] = 0; bk_bid[i] = 0; bk_price[i] = 0; bk_qty[i] = 0; bk_id[i] = 0;
        end
        bk_next_id = 1;
        bk_count = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed
        post_order(make_order(CMD_CANCEL, 1'b1, 16'hffff, 16'hffff, 32'hffffffff));
        post_order(make_order(CMD_LIMIT, 1'b0, '0, '0, '0));
        post_order(make_order(CMD_MARKET, 1'b1, '0, '0, '0));
        post_order(make_order(CMD_MARKET, 1'b1, '0, 16'd10, '0));
        post_order(make_order(CMD_LIMIT, 1'b0, 16'd100, 16'd5, '0));
        post_order(make_order(CMD_LIMIT, 1'b0, 16'd100, 16'd7, '0));
        post_order(make_order(CMD_LIMIT, 1'b0, 16'd90, 16'd3, '0));
        post_order(make_order(CMD_LIMIT, 1'b0, 16'hffff, 16'hffff, '0));
        post_order(make_order(CMD_LIMIT, 1'b1, 16'd100, 16'd10, '0));
        post_order(make_order(CMD_LIMIT, 1'b1, 16'd99, 16'd20, '0));
        post_order(make_order(CMD_MARKET, 1'b1, '0, 16'd100, '0));
        post_order(make_order(CMD_MARKET, 1'b0, 16'hffff, 16'd5, '0));
        post_order(make_order(CMD_LIMIT, 1'b1, '0, 16'd4, '0));
        post_order(make_order(CMD_CANCEL, 1'b0, '0, '0, 32'd10));
        post_order(make_order(CMD_CANCEL, 1'b0, '0, '0, 32'd10));
        post_order(make_order(CMD_CANCEL, 1'b0, '0, '0, '0));
        post_order(make_order(CMD_CLEAR, 1'b1, 16'hffff, 16'hffff, 32'hffffffff));
        drain();
        // fill the book, then overflow it
        for (int i = 0; i < SLOTS + 2; i++)
            post_order(make_order(CMD_LIMIT, 1'b1, 16'(50 + i % 3), 16'(1 + i), '0));
        // sweep the whole book
        post_order(make_order(CMD_MARKET, 1'b0, '0, 16'hffff, '0));
        post_order(make_order(CMD_CLEAR, 1'b0, '0, '0, '0));
        drain();

        random_phase(15, 0, 0);
        random_phase(15, 61, 0);
        random_phase(15, 0, 61);
        random_phase(15, 35, 35);

        // long receiver hold while orders keep coming
        send_idle_pct = 0;
        recv_stall_pct = 20;
        hold_cycles = 3000;
        for (int i = 0; i < 20; i++) post_order(random_order());
        drain();

        repeat (200) @(posedge i_clk);
        if (errors == 0 && report_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> filelist.f
hdl/lob_pkg.sv
hdl/lob_in_if.sv
hdl/lob_out_if.sv
hdl/lob_ctrl.sv
hdl/lob_dp.sv
hdl/limit_order_book_matcher.sv
verif/tb_limit_order_book_matcher.sv
